FILE: design/json_response_validator_unit_macros.svh
// Assertion macros for the JSON response validator.
// Included by modules that carry concurrent checks; no other dependencies.
`ifndef JSON_RESPONSE_VALIDATOR_UNIT_MACROS_SVH
`define JSON_RESPONSE_VALIDATOR_UNIT_MACROS_SVH

// Concurrent check on the rising clock edge, disabled while reset is low.
`define JRV_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`endif

FILE: design/jrv_pkg.sv
// Types and constants for the JSON response validator.
// Used by json_response_validator_unit and the testbench; no dependencies.
package jrv_pkg;

    typedef enum logic [4:0] {
        PH_OPEN          = 5'd0,
        PH_KEY_OR_CLOSE  = 5'd1,
        PH_KEY           = 5'd2,
        PH_KSTR          = 5'd3,
        PH_KESC          = 5'd4,
        PH_KHEX          = 5'd5,
        PH_COLON         = 5'd6,
        PH_VALUE         = 5'd7,
        PH_ELEM_OR_CLOSE = 5'd8,
        PH_VSTR          = 5'd9,
        PH_VESC          = 5'd10,
        PH_VHEX          = 5'd11,
        PH_TRUE          = 5'd12,
        PH_FALSE         = 5'd13,
        PH_NULL          = 5'd14,
        PH_N_MINUS       = 5'd15,
        PH_N_ZERO        = 5'd16,
        PH_N_INT         = 5'd17,
        PH_N_DOT         = 5'd18,
        PH_N_FRAC        = 5'd19,
        PH_N_EXP         = 5'd20,
        PH_N_EXPSIGN     = 5'd21,
        PH_N_EXPDIG      = 5'd22,
        PH_VER           = 5'd23,
        PH_AFTER         = 5'd24,
        PH_DONE          = 5'd25,
        PH_FAIL          = 5'd26
    } phase_t;

    localparam logic [2:0] FAIL_NONE      = 3'd0;
    localparam logic [2:0] FAIL_TOO_LONG  = 3'd1;
    localparam logic [2:0] FAIL_SYNTAX    = 3'd2;
    localparam logic [2:0] FAIL_DUP       = 3'd3;
    localparam logic [2:0] FAIL_VERSION   = 3'd4;
    localparam logic [2:0] FAIL_MISSING   = 3'd5;
    localparam logic [2:0] FAIL_UNTERM    = 3'd6;

    localparam logic [1:0] KM_VERSION = 2'd1;
    localparam logic [1:0] KM_STATUS  = 2'd2;

    localparam logic [15:0] MAX_BYTES_RESET = 16'd1024;
    localparam logic [31:0] VERSION_MAX     = 32'h7FFF_FFFF;

    localparam int unsigned VER_KEY_LEN    = 16;
    localparam int unsigned STATUS_KEY_LEN = 6;

    // Character of the version member name at a position.
    function automatic logic [7:0] ver_key_char(input logic [4:0] pos);
        logic [7:0] ch;
        case (pos[3:0])
            4'd0:  ch = "p";
            4'd1:  ch = "r";
            4'd2:  ch = "o";
            4'd3:  ch = "t";
            4'd4:  ch = "o";
            4'd5:  ch = "c";
            4'd6:  ch = "o";
            4'd7:  ch = "l";
            4'd8:  ch = "_";
            4'd9:  ch = "v";
            4'd10: ch = "e";
            4'd11: ch = "r";
            4'd12: ch = "s";
            4'd13: ch = "i";
            4'd14: ch = "o";
            default: ch = "n";
        endcase
        return ch;
    endfunction

    function automatic logic [7:0] status_key_char(input logic [4:0] pos);
        logic [7:0] ch;
        case (pos[2:0])
            3'd0: ch = "s";
            3'd1: ch = "t";
            3'd2: ch = "a";
            3'd3: ch = "t";
            3'd4: ch = "u";
            default: ch = "s";
        endcase
        return ch;
    endfunction

    // Literal letters: word 0 true, 1 false, 2 null.
    function automatic logic [7:0] lit_char(input logic [1:0] w, input logic [2:0] pos);
        logic [7:0] ch;
        ch = 8'h00;
        case (w)
            2'd0:
            begin
                case (pos)
                    3'd0: ch = "t";
                    3'd1: ch = "r";
                    3'd2: ch = "u";
                    3'd3: ch = "e";
                    default: ch = 8'h00;
                endcase
            end
            2'd1:
            begin
                case (pos)
                    3'd0: ch = "f";
                    3'd1: ch = "a";
                    3'd2: ch = "l";
                    3'd3: ch = "s";
                    3'd4: ch = "e";
                    default: ch = 8'h00;
                endcase
            end
            default:
            begin
                case (pos)
                    3'd0: ch = "n";
                    3'd1: ch = "u";
                    3'd2: ch = "l";
                    3'd3: ch = "l";
                    default: ch = 8'h00;
                endcase
            end
        endcase
        return ch;
    endfunction

    function automatic logic [2:0] lit_len(input logic [1:0] w);
        return (w == 2'd1) ? 3'd5 : 3'd4;
    endfunction

    function automatic logic is_ws(input logic [7:0] c);
        return (c == 8'h20) || (c == 8'h09) || (c == 8'h0D) || (c == 8'h0A);
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= "0") && (c <= "9");
    endfunction

    function automatic logic is_hex(input logic [7:0] c);
        return is_digit(c) || ((c >= "a") && (c <= "f")) || ((c >= "A") && (c <= "F"));
    endfunction

endpackage

FILE: design/json_response_validator_unit.sv
// JSON response validator: one byte per beat, one result beat per input beat.
// The parse step is combinational: each accepted byte's result beat is
// registered into the output buffer. The block takes one byte per cycle
// while in_ready is high. A two-entry output buffer holds up to two result
// beats while out_ready is low; after that the input stalls until a beat leaves.
// rst_n clears parse state and the output queue pointers, and sets max_bytes_reg to 1024.
`include "json_response_validator_unit_macros.svh"

module json_response_validator_unit
    import jrv_pkg::*;
#(
    parameter int MAX_NEST = 9
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic        paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  msg_byte,
    input  logic        last_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        status_char_valid,
    output logic [7:0]  status_char,
    output logic        message_done,
    output logic        message_ok,
    output logic [2:0]  fail_code,
    output logic [30:0] version_value
);

    localparam int LW = $clog2(MAX_NEST + 1);
    localparam int KW = (MAX_NEST > 1) ? $clog2(MAX_NEST) : 1;

    typedef struct packed {
        logic        sv;
        logic [7:0]  sc;
        logic        done;
        logic        ok;
        logic [2:0]  code;
        logic [30:0] ver;
    } result_t;

    logic [15:0]         max_bytes_reg;
    phase_t              phase_reg, phase_next;
    logic [MAX_NEST-1:0] kinds_reg, kinds_next;
    logic [LW-1:0]       level_reg, level_next;
    logic [4:0]          kpos_reg, kpos_next;
    logic [1:0]          kmatch_reg, kmatch_next;
    logic [2:0]          tpos_reg, tpos_next;
    logic [31:0]         vacc_reg, vacc_next;
    logic [2:0]          vflags_reg, vflags_next;
    logic                have_ver_reg, have_ver_next;
    logic                have_stat_reg, have_stat_next;
    logic [15:0]         count_reg, count_next;
    logic [2:0]          fail_reg, fail_next;

    // Two-entry output queue.
    result_t buf_reg [2];
    logic    rd_ptr_reg, wr_ptr_reg;
    logic [1:0] fill_reg;

    logic    accept, pop;
    result_t res;

    assign pready = 1'b1;
    assign prdata = {16'h0000, (paddr == 1'b0) ? max_bytes_reg : 16'h0000};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_bytes_reg <= MAX_BYTES_RESET;
        end
        else if (psel && penable && pwrite && (paddr == 1'b0))
        begin
            max_bytes_reg <= pwdata[15:0];
        end
    end

    assign in_ready  = (fill_reg != 2'd2);
    assign accept    = in_valid && in_ready;
    assign out_valid = (fill_reg != 2'd0);
    assign pop       = out_valid && out_ready;

    // ---------------- parse step ----------------
    always_comb
    begin
        logic [7:0]  c;
        logic        in_obj;
        logic        emit_v;
        logic [7:0]  emit_c;
        logic        dlv;
        logic [7:0]  dch;
        logic        key;
        logic [1:0]  m;
        logic [35:0] prod;
        logic [31:0] d;
        logic [1:0]  w;
        logic [KW-1:0] top;
        logic        do_after;
        logic [2:0]  code;

        c = msg_byte;
        phase_next = phase_reg;
        kinds_next = kinds_reg;
        level_next = level_reg;
        kpos_next = kpos_reg;
        kmatch_next = kmatch_reg;
        tpos_next = tpos_reg;
        vacc_next = vacc_reg;
        vflags_next = vflags_reg;
        have_ver_next = have_ver_reg;
        have_stat_next = have_stat_reg;
        count_next = count_reg;
        fail_next = fail_reg;
        emit_v = 1'b0;
        emit_c = 8'h00;
        dlv = 1'b0;
        dch = 8'h00;
        key = (phase_reg == PH_KSTR) || (phase_reg == PH_KESC) || (phase_reg == PH_KHEX);
        m = 2'b00;
        prod = 36'd0;
        d = {28'd0, c[3:0]};
        w = 2'd0;
        top = KW'(level_reg - LW'(1));
        in_obj = (level_reg == '0) || (kinds_reg[top] == 1'b0);
        do_after = 1'b0;
        code = FAIL_NONE;

        if (count_reg >= max_bytes_reg)
        begin
            fail_next = FAIL_TOO_LONG;
            phase_next = PH_FAIL;
        end
        else
        begin
            count_next = count_reg + 16'd1;
            unique case (phase_reg)
                PH_KSTR, PH_VSTR:
                begin
                    if (c == "\"")
                    begin
                        if (key)
                        begin
                            if (level_reg == '0)
                            begin
                                m[0] = kmatch_reg[0] && (kpos_reg == 5'(VER_KEY_LEN));
                                m[1] = kmatch_reg[1] && (kpos_reg == 5'(STATUS_KEY_LEN));
                                kmatch_next = m;
                            end
                            phase_next = PH_COLON;
                        end
                        else
                        begin
                            phase_next = PH_AFTER;
                        end
                    end
                    else if (c < 8'h20)
                    begin
                        code = FAIL_SYNTAX;
                    end
                    else if (c == "\\")
                    begin
                        phase_next = key ? PH_KESC : PH_VESC;
                    end
                    else
                    begin
                        dlv = 1'b1;
                        dch = c;
                    end
                end
                PH_KESC, PH_VESC:
                begin
                    phase_next = key ? PH_KSTR : PH_VSTR;
                    dlv = 1'b1;
                    case (c)
                        "\"", "\\", "/": dch = c;
                        "b": dch = 8'h08;
                        "f": dch = 8'h0C;
                        "n": dch = 8'h0A;
                        "r": dch = 8'h0D;
                        "t": dch = 8'h09;
                        "u":
                        begin
                            dlv = 1'b0;
                            tpos_next = 3'd0;
                            phase_next = key ? PH_KHEX : PH_VHEX;
                        end
                        default:
                        begin
                            dlv = 1'b0;
                            code = FAIL_SYNTAX;
                        end
                    endcase
                end
                PH_KHEX, PH_VHEX:
                begin
                    if (!is_hex(c))
                    begin
                        code = FAIL_SYNTAX;
                    end
                    else
                    begin
                        tpos_next = tpos_reg + 3'd1;
                        if (tpos_reg >= 3'd3)
                        begin
                            dlv = 1'b1;
                            dch = "?";
                            phase_next = key ? PH_KSTR : PH_VSTR;
                        end
                    end
                end
                PH_TRUE, PH_FALSE, PH_NULL:
                begin
                    w = 2'(phase_reg - PH_TRUE);
                    if ((tpos_reg >= lit_len(w)) || (lit_char(w, tpos_reg) != c))
                    begin
                        code = FAIL_SYNTAX;
                    end
                    else
                    begin
                        tpos_next = tpos_reg + 3'd1;
                        if (tpos_next >= lit_len(w))
                        begin
                            phase_next = PH_AFTER;
                        end
                    end
                end
                PH_OPEN:
                begin
                    if (c == "{")
                    begin
                        level_next = '0;
                        phase_next = PH_KEY_OR_CLOSE;
                    end
                    else if (!is_ws(c))
                    begin
                        code = FAIL_SYNTAX;
                    end
                end
                PH_KEY_OR_CLOSE, PH_KEY:
                begin
                    if ((c == "}") && (phase_reg == PH_KEY_OR_CLOSE))
                    begin
                        if (level_reg == '0)
                        begin
                            phase_next = PH_DONE;
                        end
                        else
                        begin
                            level_next = level_reg - LW'(1);
                            phase_next = PH_AFTER;
                        end
                    end
                    else if (c == "\"")
                    begin
                        if (level_reg == '0)
                        begin
                            kpos_next = 5'd0;
                            kmatch_next = 2'b11;
                        end
                        phase_next = PH_KSTR;
                    end
                    else if (!is_ws(c))
                    begin
                        code = FAIL_SYNTAX;
                    end
                end
                PH_COLON:
                begin
                    if (c == ":")
                    begin
                        phase_next = PH_VALUE;
                        if ((level_reg == '0) && (kmatch_reg == KM_VERSION))
                        begin
                            if (have_ver_reg)
                            begin
                                code = FAIL_DUP;
                            end
                            else
                            begin
                                have_ver_next = 1'b1;
                                vacc_next = 32'd0;
                                vflags_next = 3'd0;
                            end
                        end
                        else if ((level_reg == '0) && (kmatch_reg == KM_STATUS))
                        begin
                            if (have_stat_reg)
                            begin
                                code = FAIL_DUP;
                            end
                            else
                            begin
                                have_stat_next = 1'b1;
                            end
                        end
                    end
                    else if (!is_ws(c))
                    begin
                        code = FAIL_SYNTAX;
                    end
                end
                PH_VALUE, PH_ELEM_OR_CLOSE, PH_VER:
                begin
                    if ((phase_reg == PH_ELEM_OR_CLOSE) && (c == "]"))
                    begin
                        if (level_reg == '0)
                        begin
                            phase_next = PH_DONE;
                        end
                        else
                        begin
                            level_next = level_reg - LW'(1);
                            phase_next = PH_AFTER;
                        end
                    end
                    else if ((phase_reg != PH_VER) && is_ws(c))
                    begin
                        phase_next = phase_reg;
                    end
                    else if ((phase_reg == PH_VER) ||
                             ((phase_reg == PH_VALUE) && (level_reg == '0) &&
                              (kmatch_reg == KM_VERSION)))
                    begin
                        // Version number digits, accumulated as they arrive.
                        phase_next = PH_VER;
                        if ((c == "-") && (vflags_reg == 3'd0))
                        begin
                            vflags_next = 3'd1;
                        end
                        else if (is_digit(c))
                        begin
                            if (!vflags_reg[2])
                            begin
                                vflags_next = vflags_reg | 3'b100;
                                if (d == 32'd0)
                                begin
                                    vflags_next[1] = 1'b1;
                                    vacc_next = d;
                                end
                                else if (vflags_reg[0])
                                begin
                                    code = FAIL_VERSION;
                                end
                                else
                                begin
                                    vacc_next = d;
                                end
                            end
                            else
                            begin
                                prod = {vacc_reg, 3'b000} + {vacc_reg, 1'b0} + {4'd0, d};
                                if (vflags_reg[1] || (prod > {4'd0, VERSION_MAX}))
                                begin
                                    code = FAIL_VERSION;
                                end
                                else
                                begin
                                    vacc_next = prod[31:0];
                                end
                            end
                        end
                        else if (!vflags_reg[2] || (c == ".") || (c == "e") || (c == "E"))
                        begin
                            code = FAIL_VERSION;
                        end
                        else
                        begin
                            do_after = 1'b1;
                        end
                    end
                    else if ((phase_reg == PH_VALUE) && (level_reg == '0) &&
                             (kmatch_reg == KM_STATUS))
                    begin
                        if (c == "\"")
                        begin
                            phase_next = PH_VSTR;
                        end
                        else
                        begin
                            code = FAIL_SYNTAX;
                        end
                    end
                    else if (level_reg >= LW'(MAX_NEST))
                    begin
                        code = FAIL_SYNTAX;
                    end
                    else
                    begin
                        tpos_next = 3'd1;
                        case (c)
                            "\"": phase_next = PH_VSTR;
                            "{":
                            begin
                                kinds_next[KW'(level_reg)] = 1'b0;
                                level_next = level_reg + LW'(1);
                                phase_next = PH_KEY_OR_CLOSE;
                            end
                            "[":
                            begin
                                kinds_next[KW'(level_reg)] = 1'b1;
                                level_next = level_reg + LW'(1);
                                phase_next = PH_ELEM_OR_CLOSE;
                            end
                            "t": phase_next = PH_TRUE;
                            "f": phase_next = PH_FALSE;
                            "n": phase_next = PH_NULL;
                            "-": phase_next = PH_N_MINUS;
                            "0": phase_next = PH_N_ZERO;
                            default:
                            begin
                                if (is_digit(c))
                                begin
                                    phase_next = PH_N_INT;
                                end
                                else
                                begin
                                    code = FAIL_SYNTAX;
                                end
                            end
                        endcase
                    end
                end
                PH_N_MINUS:
                begin
                    if (c == "0")
                        phase_next = PH_N_ZERO;
                    else if (is_digit(c))
                        phase_next = PH_N_INT;
                    else
                        code = FAIL_SYNTAX;
                end
                PH_N_ZERO, PH_N_INT:
                begin
                    if (is_digit(c))
                    begin
                        if (phase_reg == PH_N_ZERO)
                            code = FAIL_SYNTAX;
                    end
                    else if (c == ".")
                        phase_next = PH_N_DOT;
                    else if ((c == "e") || (c == "E"))
                        phase_next = PH_N_EXP;
                    else
                        do_after = 1'b1;
                end
                PH_N_DOT:
                begin
                    if (is_digit(c))
                        phase_next = PH_N_FRAC;
                    else
                        code = FAIL_SYNTAX;
                end
                PH_N_FRAC:
                begin
                    if ((c == "e") || (c == "E"))
                        phase_next = PH_N_EXP;
                    else if (!is_digit(c))
                        do_after = 1'b1;
                end
                PH_N_EXP:
                begin
                    if ((c == "+") || (c == "-"))
                        phase_next = PH_N_EXPSIGN;
                    else if (is_digit(c))
                        phase_next = PH_N_EXPDIG;
                    else
                        code = FAIL_SYNTAX;
                end
                PH_N_EXPSIGN:
                begin
                    if (is_digit(c))
                        phase_next = PH_N_EXPDIG;
                    else
                        code = FAIL_SYNTAX;
                end
                PH_N_EXPDIG:
                begin
                    if (!is_digit(c))
                        do_after = 1'b1;
                end
                PH_AFTER:
                begin
                    do_after = 1'b1;
                end
                PH_DONE:
                begin
                    if (!is_ws(c))
                        code = FAIL_SYNTAX;
                end
                default:
                begin
                    phase_next = phase_reg;
                end
            endcase

            if (do_after)
            begin
                phase_next = PH_AFTER;
                if (is_ws(c))
                begin
                    phase_next = PH_AFTER;
                end
                else if (c == ",")
                begin
                    phase_next = in_obj ? PH_KEY : PH_VALUE;
                end
                else if (((c == "}") && in_obj) || ((c == "]") && !in_obj))
                begin
                    if (level_reg == '0)
                    begin
                        phase_next = PH_DONE;
                    end
                    else
                    begin
                        level_next = level_reg - LW'(1);
                        phase_next = PH_AFTER;
                    end
                end
                else
                begin
                    code = FAIL_SYNTAX;
                end
            end

            // Decoded string characters go to key matching or the status output.
            if (dlv && (code == FAIL_NONE) && (level_reg == '0))
            begin
                if (key)
                begin
                    m = kmatch_reg;
                    if ((kpos_reg >= 5'(VER_KEY_LEN)) || (ver_key_char(kpos_reg) != dch))
                        m[0] = 1'b0;
                    if ((kpos_reg >= 5'(STATUS_KEY_LEN)) || (status_key_char(kpos_reg) != dch))
                        m[1] = 1'b0;
                    kmatch_next = m;
                    if (kpos_reg != 5'd31)
                        kpos_next = kpos_reg + 5'd1;
                end
                else if (kmatch_reg == KM_STATUS)
                begin
                    emit_v = 1'b1;
                    emit_c = dch;
                end
            end

            if (code != FAIL_NONE)
            begin
                if (fail_reg == FAIL_NONE)
                    fail_next = code;
                phase_next = PH_FAIL;
            end
        end

        res.sv   = emit_v;
        res.sc   = emit_c;
        res.done = last_byte;
        res.ok   = 1'b0;
        res.code = FAIL_NONE;
        res.ver  = 31'd0;
        if (last_byte)
        begin
            if (fail_next != FAIL_NONE)
                res.code = fail_next;
            else if ((phase_next == PH_VER) && !vflags_next[2])
                res.code = FAIL_VERSION;
            else if (phase_next != PH_DONE)
                res.code = FAIL_UNTERM;
            else if (!have_ver_next || !have_stat_next)
                res.code = FAIL_MISSING;
            else
            begin
                res.ok  = 1'b1;
                res.ver = vacc_next[30:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_OPEN;
            kinds_reg     <= '0;
            level_reg     <= '0;
            kpos_reg      <= 5'd0;
            kmatch_reg    <= 2'd0;
            tpos_reg      <= 3'd0;
            vacc_reg      <= 32'd0;
            vflags_reg    <= 3'd0;
            have_ver_reg  <= 1'b0;
            have_stat_reg <= 1'b0;
            count_reg     <= 16'd0;
            fail_reg      <= FAIL_NONE;
        end
        else if (accept)
        begin
            if (last_byte)
            begin
                phase_reg     <= PH_OPEN;
                kinds_reg     <= '0;
                level_reg     <= '0;
                kpos_reg      <= 5'd0;
                kmatch_reg    <= 2'd0;
                tpos_reg      <= 3'd0;
                vacc_reg      <= 32'd0;
                vflags_reg    <= 3'd0;
                have_ver_reg  <= 1'b0;
                have_stat_reg <= 1'b0;
                count_reg     <= 16'd0;
                fail_reg      <= FAIL_NONE;
            end
            else
            begin
                phase_reg     <= phase_next;
                kinds_reg     <= kinds_next;
                level_reg     <= level_next;
                kpos_reg      <= kpos_next;
                kmatch_reg    <= kmatch_next;
                tpos_reg      <= tpos_next;
                vacc_reg      <= vacc_next;
                vflags_reg    <= vflags_next;
                have_ver_reg  <= have_ver_next;
                have_stat_reg <= have_stat_next;
                count_reg     <= count_next;
                fail_reg      <= fail_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            buf_reg[wr_ptr_reg] <= res;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_ptr_reg <= 1'b0;
            wr_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            if (accept)
                wr_ptr_reg <= ~wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= ~rd_ptr_reg;
            fill_reg <= fill_reg + {1'b0, accept} - {1'b0, pop};
        end
    end

    assign status_char_valid = buf_reg[rd_ptr_reg].sv;
    assign status_char       = buf_reg[rd_ptr_reg].sc;
    assign message_done      = buf_reg[rd_ptr_reg].done;
    assign message_ok        = buf_reg[rd_ptr_reg].ok;
    assign fail_code         = buf_reg[rd_ptr_reg].code;
    assign version_value     = buf_reg[rd_ptr_reg].ver;

    `JRV_ASSERT(a_fill_range, clk, rst_n, (fill_reg != 2'd3), "output queue fill out of range")
    `JRV_ASSERT(a_nest_bound, clk, rst_n, (level_reg <= LW'(MAX_NEST)), "nesting level overflow")
    `JRV_ASSERT(a_ok_code, clk, rst_n, (out_valid && message_ok) |-> (fail_code == FAIL_NONE && message_done), "accepted message with fail code")
    `JRV_ASSERT(a_fail_sticky, clk, rst_n, (accept && !last_byte && fail_reg != FAIL_NONE && fail_next != FAIL_TOO_LONG) |=> (fail_reg == $past(fail_reg)), "first failure overwritten")

endmodule

FILE: sim/tb.sv
// Testbench for json_response_validator_unit: streams messages in, predicts every result
// beat with its own parser, and compares each field. Depends on jrv_pkg and the RTL.
module tb;
    import jrv_pkg::*;

    localparam int NEST_LIMIT = 9;

    typedef struct packed {
        bit        char_valid;
        bit [7:0]  char_code;
        bit        done;
        bit        ok;
        bit [2:0]  code;
        bit [30:0] version;
    } verdict_t;

    typedef byte unsigned msg_q_t[$];

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic        paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        in_valid;
    logic        in_ready;
    logic [7:0]  msg_byte;
    logic        last_byte;
    logic        out_valid;
    logic        out_ready;
    logic        status_char_valid;
    logic [7:0]  status_char;
    logic        message_done;
    logic        message_ok;
    logic [2:0]  fail_code;
    logic [30:0] version_value;

    json_response_validator_unit #(.MAX_NEST(NEST_LIMIT)) DUT (.*);

    // Parser state mirrored from the block.
    phase_t      parse_state;
    bit          nest_kind[NEST_LIMIT];
    int          depth;
    int          key_idx;
    bit [1:0]    key_hits;
    int          tok_idx;
    longint      ver_acc;
    bit [2:0]    ver_flags;
    bit          seen_ver;
    bit          seen_status;
    int          byte_cnt;
    bit [2:0]    err_code;
    bit          char_out;
    bit [7:0]    char_val;
    int          max_bytes;

    verdict_t    pending_results[$];
    int          errors;
    bit          quiet;
    int          stall_left;

    string ver_name = {"protocol", "_version"};
    string status_name = "status";
    string lit_words[3] = '{"true", "false", "null"};

    // Quoted version member name followed by its colon.
    function automatic string vkey();
        return {"\"protocol", "_version\":"};
    endfunction

    function automatic bit ws_c(byte unsigned c);
        return c == 8'h20 || c == 8'h09 || c == 8'h0D || c == 8'h0A;
    endfunction

    function automatic bit dig_c(byte unsigned c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic bit hex_c(byte unsigned c);
        return dig_c(c) || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
    endfunction

    task automatic clear_msg();
        parse_state = PH_OPEN;
        foreach (nest_kind[i]) nest_kind[i] = 0;
        depth = 0;
        key_idx = 0;
        key_hits = 0;
        tok_idx = 0;
        ver_acc = 0;
        ver_flags = 0;
        seen_ver = 0;
        seen_status = 0;
        byte_cnt = 0;
        err_code = FAIL_NONE;
    endtask

    task automatic flag_error(bit [2:0] code);
        if (err_code == FAIL_NONE)
            err_code = code;
        parse_state = PH_FAIL;
    endtask

    task automatic close_level();
        if (depth == 0)
            parse_state = PH_DONE;
        else
        begin
            depth--;
            parse_state = PH_AFTER;
        end
    endtask

    task automatic after_item(byte unsigned c);
        bit in_obj;
        in_obj = (depth == 0) || (nest_kind[depth-1] == 0);
        if (ws_c(c))
            return;
        if (c == ",")
            parse_state = in_obj ? PH_KEY : PH_VALUE;
        else if ((c == "}" && in_obj) || (c == "]" && !in_obj))
            close_level();
        else
            flag_error(FAIL_SYNTAX);
    endtask

    task automatic open_key();
        if (depth == 0)
        begin
            key_idx = 0;
            key_hits = 2'b11;
        end
        parse_state = PH_KSTR;
    endtask

    task automatic open_level(bit kind, phase_t next);
        nest_kind[depth] = kind;
        depth++;
        parse_state = next;
    endtask

    task automatic begin_value(byte unsigned c);
        if (depth >= NEST_LIMIT)
        begin
            flag_error(FAIL_SYNTAX);
            return;
        end
        tok_idx = 1;
        case (c)
            "\"": parse_state = PH_VSTR;
            "{": open_level(0, PH_KEY_OR_CLOSE);
            "[": open_level(1, PH_ELEM_OR_CLOSE);
            "t": parse_state = PH_TRUE;
            "f": parse_state = PH_FALSE;
            "n": parse_state = PH_NULL;
            "-": parse_state = PH_N_MINUS;
            "0": parse_state = PH_N_ZERO;
            default:
                if (dig_c(c)) parse_state = PH_N_INT;
                else flag_error(FAIL_SYNTAX);
        endcase
    endtask

    task automatic version_char(byte unsigned c);
        longint d;
        longint v;
        if (c == "-" && ver_flags == 0)
            ver_flags = 3'b001;
        else if (dig_c(c))
        begin
            d = c - "0";
            if (!ver_flags[2])
            begin
                ver_flags[2] = 1;
                if (d == 0)
                    ver_flags[1] = 1;
                else if (ver_flags[0])
                begin
                    flag_error(FAIL_VERSION);
                    return;
                end
                ver_acc = d;
            end
            else
            begin
                v = ver_acc * 10 + d;
                if (ver_flags[1] || v > longint'(VERSION_MAX))
                begin
                    flag_error(FAIL_VERSION);
                    return;
                end
                ver_acc = v;
            end
        end
        else if (!ver_flags[2] || c == "." || c == "e" || c == "E")
            flag_error(FAIL_VERSION);
        else
        begin
            parse_state = PH_AFTER;
            after_item(c);
        end
    endtask

    task automatic decoded_char(byte unsigned ch, bit key);
        bit [1:0] m;
        if (depth != 0)
            return;
        if (key)
        begin
            m = key_hits;
            if (key_idx >= VER_KEY_LEN || ver_name[key_idx] != ch) m[0] = 0;
            if (key_idx >= STATUS_KEY_LEN || status_name[key_idx] != ch) m[1] = 0;
            key_hits = m;
            if (key_idx < 31) key_idx++;
        end
        else if (key_hits == KM_STATUS)
        begin
            char_out = 1;
            char_val = ch;
        end
    endtask

    // Shared by key strings and value strings; base is the plain-text phase.
    task automatic string_char(byte unsigned c, phase_t base, bit key);
        int sub;
        int dec;
        bit [1:0] m;
        sub = int'(parse_state) - int'(base);
        if (sub == 0)
        begin
            if (c == "\"")
            begin
                if (key)
                begin
                    if (depth == 0)
                    begin
                        m = 0;
                        if (key_hits[0] && key_idx == VER_KEY_LEN) m[0] = 1;
                        if (key_hits[1] && key_idx == STATUS_KEY_LEN) m[1] = 1;
                        key_hits = m;
                    end
                    parse_state = PH_COLON;
                end
                else
                    parse_state = PH_AFTER;
            end
            else if (c < 8'h20)
                flag_error(FAIL_SYNTAX);
            else if (c == "\\")
                parse_state = phase_t'(base + 1);
            else
                decoded_char(c, key);
        end
        else if (sub == 1)
        begin
            case (c)
                "\"", "\\", "/": dec = c;
                "b": dec = 8'h08;
                "f": dec = 8'h0C;
                "n": dec = 8'h0A;
                "r": dec = 8'h0D;
                "t": dec = 8'h09;
                "u": dec = 256;
                default: dec = 257;
            endcase
            if (dec == 256)
            begin
                tok_idx = 0;
                parse_state = phase_t'(base + 2);
            end
            else if (dec > 255)
                flag_error(FAIL_SYNTAX);
            else
            begin
                decoded_char(dec[7:0], key);
                parse_state = base;
            end
        end
        else if (!hex_c(c))
            flag_error(FAIL_SYNTAX);
        else
        begin
            tok_idx++;
            if (tok_idx >= 4)
            begin
                decoded_char("?", key);
                parse_state = base;
            end
        end
    endtask

    task automatic parse_char(byte unsigned c);
        int w;
        case (parse_state)
            PH_KSTR, PH_KESC, PH_KHEX: string_char(c, PH_KSTR, 1);
            PH_VSTR, PH_VESC, PH_VHEX: string_char(c, PH_VSTR, 0);
            PH_TRUE, PH_FALSE, PH_NULL:
            begin
                w = int'(parse_state) - int'(PH_TRUE);
                if (tok_idx >= lit_words[w].len() || lit_words[w][tok_idx] != c)
                    flag_error(FAIL_SYNTAX);
                else
                begin
                    tok_idx++;
                    if (tok_idx >= lit_words[w].len())
                        parse_state = PH_AFTER;
                end
            end
            PH_OPEN:
                if (c == "{")
                begin
                    depth = 0;
                    parse_state = PH_KEY_OR_CLOSE;
                end
                else if (!ws_c(c)) flag_error(FAIL_SYNTAX);
            PH_KEY_OR_CLOSE:
                if (c == "}") close_level();
                else if (c == "\"") open_key();
                else if (!ws_c(c)) flag_error(FAIL_SYNTAX);
            PH_KEY:
                if (c == "\"") open_key();
                else if (!ws_c(c)) flag_error(FAIL_SYNTAX);
            PH_COLON:
                if (c == ":")
                begin
                    if (depth == 0 && key_hits == KM_VERSION)
                    begin
                        if (seen_ver)
                        begin
                            flag_error(FAIL_DUP);
                            return;
                        end
                        seen_ver = 1;
                        ver_acc = 0;
                        ver_flags = 0;
                    end
                    else if (depth == 0 && key_hits == KM_STATUS)
                    begin
                        if (seen_status)
                        begin
                            flag_error(FAIL_DUP);
                            return;
                        end
                        seen_status = 1;
                    end
                    parse_state = PH_VALUE;
                end
                else if (!ws_c(c)) flag_error(FAIL_SYNTAX);
            PH_VALUE:
                if (!ws_c(c))
                begin
                    if (depth == 0 && key_hits == KM_VERSION)
                    begin
                        parse_state = PH_VER;
                        version_char(c);
                    end
                    else if (depth == 0 && key_hits == KM_STATUS)
                    begin
                        if (c == "\"") parse_state = PH_VSTR;
                        else flag_error(FAIL_SYNTAX);
                    end
                    else
                        begin_value(c);
                end
            PH_ELEM_OR_CLOSE:
                if (c == "]") close_level();
                else if (!ws_c(c)) begin_value(c);
            PH_N_MINUS:
                if (c == "0") parse_state = PH_N_ZERO;
                else if (dig_c(c)) parse_state = PH_N_INT;
                else flag_error(FAIL_SYNTAX);
            PH_N_ZERO, PH_N_INT:
                if (dig_c(c))
                begin
                    if (parse_state == PH_N_ZERO) flag_error(FAIL_SYNTAX);
                end
                else if (c == ".") parse_state = PH_N_DOT;
                else if (c == "e" || c == "E") parse_state = PH_N_EXP;
                else
                begin
                    parse_state = PH_AFTER;
                    after_item(c);
                end
            PH_N_DOT:
                if (dig_c(c)) parse_state = PH_N_FRAC;
                else flag_error(FAIL_SYNTAX);
            PH_N_FRAC:
                if (c == "e" || c == "E") parse_state = PH_N_EXP;
                else if (!dig_c(c))
                begin
                    parse_state = PH_AFTER;
                    after_item(c);
                end
            PH_N_EXP:
                if (c == "+" || c == "-") parse_state = PH_N_EXPSIGN;
                else if (dig_c(c)) parse_state = PH_N_EXPDIG;
                else flag_error(FAIL_SYNTAX);
            PH_N_EXPSIGN:
                if (dig_c(c)) parse_state = PH_N_EXPDIG;
                else flag_error(FAIL_SYNTAX);
            PH_N_EXPDIG:
                if (!dig_c(c))
                begin
                    parse_state = PH_AFTER;
                    after_item(c);
                end
            PH_VER: version_char(c);
            PH_AFTER: after_item(c);
            PH_DONE: if (!ws_c(c)) flag_error(FAIL_SYNTAX);
            default: ;
        endcase
    endtask

    // Works out the result beat for one accepted byte.
    task automatic judge_byte(byte unsigned c, bit last, output verdict_t r);
        r = '0;
        char_out = 0;
        char_val = 0;
        if (byte_cnt >= max_bytes)
        begin
            err_code = FAIL_TOO_LONG;
            parse_state = PH_FAIL;
        end
        else
        begin
            byte_cnt++;
            parse_char(c);
        end
        r.char_valid = char_out;
        r.char_code = char_out ? char_val : 8'h00;
        if (last)
        begin
            r.done = 1;
            if (err_code != FAIL_NONE)
                r.code = err_code;
            else if (parse_state == PH_VER && !ver_flags[2])
                r.code = FAIL_VERSION;
            else if (parse_state != PH_DONE)
                r.code = FAIL_UNTERM;
            else if (!seen_ver || !seen_status)
                r.code = FAIL_MISSING;
            else
            begin
                r.ok = 1;
                r.version = ver_acc[30:0];
            end
            clear_msg();
        end
    endtask

    task automatic report(string field, longint got, longint want);
        $display("mismatch at %0t: %s got %0h expected %0h", $realtime, field, got, want);
        errors++;
    endtask

    initial
    begin
        clk = 0;
        forever #4 clk = ~clk;
    end

    // Result side: a check of every beat taken, and random stall bursts on out_ready.
    always @(posedge clk)
    begin
        verdict_t e;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_results.size() == 0)
                report("unexpected beat", 1, 0);
            else
            begin
                e = pending_results.pop_front();
                if (status_char_valid !== e.char_valid)
                    report("status_char_valid", status_char_valid, e.char_valid);
                if (status_char !== e.char_code) report("status_char", status_char, e.char_code);
                if (message_done !== e.done) report("message_done", message_done, e.done);
                if (message_ok !== e.ok) report("message_ok", message_ok, e.ok);
                if (fail_code !== e.code) report("fail_code", fail_code, e.code);
                if (version_value !== e.version)
                    report("version_value", version_value, e.version);
            end
        end
        if (stall_left > 0)
        begin
            stall_left--;
            out_ready <= (stall_left == 0);
        end
        else if (!quiet && $urandom_range(0, 9) == 0)
        begin
            stall_left = $urandom_range(1, 10);
            out_ready <= 0;
        end
        else
            out_ready <= 1;
    end

    task automatic reg_write(bit [15:0] value);
        @(posedge clk);
        psel <= 1;
        penable <= 0;
        pwrite <= 1;
        paddr <= 0;
        pwdata <= value;
        @(posedge clk);
        penable <= 1;
        @(posedge clk);
        psel <= 0;
        penable <= 0;
        pwrite <= 0;
        max_bytes = value;
    endtask

    // Called right after an accepting edge; valid drops so no beat is taken twice.
    task automatic drain();
        in_valid <= 0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic send_byte(byte unsigned c, bit last);
        verdict_t r;
        if (!quiet && $urandom_range(0, 5) == 0)
        begin
            in_valid <= 0;
            repeat ($urandom_range(1, 10)) @(posedge clk);
        end
        in_valid <= 1;
        msg_byte <= c;
        last_byte <= last;
        do
            @(posedge clk);
        while (!in_ready);
        judge_byte(c, last, r);
        pending_results.insert(pending_results.size(), r);
    endtask

    task automatic send_msg(msg_q_t m);
        foreach (m[i])
            send_byte(m[i], i == m.size() - 1);
    endtask

    task automatic send_text(string s);
        msg_q_t m;
        for (int i = 0; i < s.len(); i++)
            m.insert(m.size(), s[i]);
        send_msg(m);
    endtask

    function automatic string rand_ws();
        string opts[5] = '{"", "", " ", "\n\t", "\r "};
        return opts[$urandom_range(0, 4)];
    endfunction

    function automatic string rand_text();
        string s;
        string pieces[8] = '{"ok", "A", "\\n", "\\\"", "\\u00eF", "\\/", "~z", "\\t"};
        s = "\"";
        repeat ($urandom_range(0, 4)) s = {s, pieces[$urandom_range(0, 7)]};
        return {s, "\""};
    endfunction

    function automatic string rand_version();
        case ($urandom_range(0, 7))
            0: return "2147483647";
            1: return "2147483648";
            2: return "-0";
            3: return $sformatf("%0d", $urandom() & 32'h7FFF_FFFF);
            4: return "007";
            5: return "1.5";
            default: return $sformatf("%0d", $urandom_range(0, 99));
        endcase
    endfunction

    function automatic string rand_value(int lvl);
        string s;
        int k;
        case ($urandom_range(0, 8))
            0: return rand_text();
            1: return "true";
            2: return "false";
            3: return "null";
            4: return "-12.5e+3";
            5: return $sformatf("%0d", $urandom_range(0, 9999));
            6:
            begin
                if (lvl > 2) return "0";
                s = "[";
                k = $urandom_range(0, 3);
                for (int i = 0; i < k; i++)
                    s = {s, (i ? "," : ""), rand_ws(), rand_value(lvl + 1)};
                return {s, "]"};
            end
            7:
            begin
                if (lvl > 2) return "1E2";
                s = "{";
                k = $urandom_range(0, 2);
                for (int i = 0; i < k; i++)
                    s = {s, (i ? "," : ""), "\"status\":", rand_value(lvl + 1)};
                return {s, "}"};
            end
            default:
            begin
                // Deep chains straddle the nesting limit.
                k = $urandom_range(7, 11);
                s = "";
                repeat (k) s = {s, "["};
                s = {s, "1"};
                repeat (k) s = {s, "]"};
                return s;
            end
        endcase
    endfunction

    function automatic msg_q_t rand_message();
        string members[$];
        string s;
        msg_q_t m;
        string keys[4] = '{"a", "statu", "st\\u0061tus", "protocol_versio"};
        if ($urandom_range(0, 99) < 85)
            members.insert(members.size(), {"\"status\":", rand_text()});
        if ($urandom_range(0, 99) < 85)
            members.insert(members.size(), {vkey(), rand_ws(), rand_version()});
        if ($urandom_range(0, 99) < 8) members.insert(members.size(), "\"status\":\"x\"");
        repeat ($urandom_range(0, 2))
            members.insert(members.size(), {"\"", keys[$urandom_range(0, 3)], "\"",
                rand_ws(), ":", rand_value(0)});
        members.shuffle();
        s = {rand_ws(), "{"};
        foreach (members[i])
            s = {s, (i ? "," : ""), rand_ws(), members[i]};
        s = {s, "}", rand_ws()};
        for (int i = 0; i < s.len(); i++)
            m.insert(m.size(), s[i]);
        if ($urandom_range(0, 9) < 2)
            m[$urandom_range(0, m.size() - 1)] = $urandom_range(0, 255);
        if ($urandom_range(0, 9) == 0 && m.size() > 1)
            m = m[0:$urandom_range(0, m.size() - 2)];
        return m;
    endfunction

    task automatic test_grammar();
        send_text({"{\"status\":\"ok\",", vkey(), "3}"});
        send_text({" {\"st\\u0061tus\" : \"a\\u12Fb\\n\\\"\\\\\\/\\b\\f\\r\\t\", ",
            vkey(), "0} \n"});
        send_text({"{\"x\":[[[[[[[[1]]]]]]]],\"status\":\"\",", vkey(), "1}"});
        send_text("{\"x\":[[[[[[[[[1]]]]]]]]]}");
        send_text("{\"x\":{\"status\":[true,false,null,-0.5e-2,10E3]}}");
        send_text("{\"status\":\"a\",\"status\":\"b\"}");
        send_text("{\"status\":\"ok\"}");
        send_text("{\"status\":1}");
        send_text("{\"status\":\"bad\\q\"}");
        send_text("{\"status\":\"ok\"");
        send_text("{\"status\":\"ok\"} x");
        send_text("{\"a\":01}");
        send_text("{\"a\":tru}");
        send_text("{\"a\":\"\\u12g4\"}");
        send_msg('{8'h7B, 8'h22, 8'h00, 8'h22});
        send_msg('{8'hFF});
        send_text("}");
    endtask

    task automatic test_version_rules();
        send_text({"{\"status\":\"\",", vkey(), "-0}"});
        send_text({"{\"status\":\"\",", vkey(), "2147483647}"});
        send_text({"{\"status\":\"\",", vkey(), "2147483648}"});
        send_text({"{", vkey(), "-1,\"status\":\"\"}"});
        send_text({"{", vkey(), "1.0}"});
        send_text({"{", vkey(), "1e1}"});
        send_text({"{", vkey(), "\"1\"}"});
        send_text({"{", vkey(), "1,", vkey(), "1}"});
        send_text({"{", vkey(), "-"});
    endtask

    task automatic test_length_limit();
        drain();
        reg_write(16'd20);
        send_text("{\"status\":\"abcdefghijklmn\"}");
        send_text({"{\"status\":\"\",", vkey(), "1}"});
        send_text("{\"status\":\"abc\"}");
        drain();
        reg_write(16'd1);
        send_text("{}");
        send_text("{");
        drain();
        reg_write(16'hFFFF);
        send_text({"{\"status\":\"ok\",", vkey(), "65535}"});
        drain();
        reg_write(16'd1024);
    endtask

    task automatic test_random_messages();
        msg_q_t m;
        int sent;
        sent = 0;
        while (sent < 400)
        begin
            if (sent > 320)
                quiet = 1;
            if ($urandom_range(0, 9) == 0)
            begin
                m.delete();
                repeat ($urandom_range(1, 12)) m.insert(m.size(), $urandom_range(0, 255));
            end
            else
                m = rand_message();
            send_msg(m);
            sent += m.size();
        end
    endtask

    initial
    begin
        errors = 0;
        quiet = 0;
        stall_left = 0;
        max_bytes = MAX_BYTES_RESET;
        clear_msg();
        rst_n = 0;
        psel = 0;
        penable = 0;
        pwrite = 0;
        paddr = 0;
        pwdata = 0;
        in_valid = 0;
        msg_byte = 0;
        last_byte = 0;
        out_ready = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1;
        test_grammar();
        test_version_rules();
        test_length_limit();
        test_random_messages();
        drain();
        if (errors == 0)
            $display("json_response_validator_unit regression: pass");
        else
            $display("json_response_validator_unit regression: fail");
        $finish;
    end

    initial
    begin
        #5000000;
        $display("json_response_validator_unit regression: fail");
        $finish;
    end

endmodule
